FILE: design/sfe_pkg.sv
// Shared types, constants and the digest step function of the sensor frame encoder.
package sfe_pkg;

    localparam int FRAME_LEN  = 18;
    localparam int POS_W      = 5;
    localparam int DIGEST_LEN = 15;
    localparam int STEP_W     = 4;

    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(FRAME_LEN - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIGEST_LEN - 1);

    localparam logic [15:0] GEN_RESET  = 16'h8810;
    localparam logic [15:0] KEY_RESET  = 16'h5412;
    localparam logic [3:0]  TYPE_RESET = 4'h2;

    localparam logic [7:0] UV_HIGH = 8'hFF;
    localparam logic [7:0] UV_LOW  = 8'h00;

    // Register slots on the APB port (word addresses)
    typedef enum logic [1:0] {
        REG_GENERATOR = 2'd0,
        REG_KEY       = 2'd1,
        REG_TYPE      = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] generator;
        logic [15:0] key;
        logic [3:0]  sensor_type;
    } cfg_t;

    // One classified reading as handed from front to back
    typedef struct packed {
        logic [15:0] digest;
        logic [31:0] sensor_id;
        logic [7:0]  type_chan;
        logic [7:0]  temp_hi;
        logic [7:0]  temp_lo;
        logic [7:0]  hum_bcd;
        logic [7:0]  checksum;
    } frame_t;

    typedef struct packed {
        logic [15:0] acc;
        logic [15:0] key;
    } digest_t;

    // Eight LFSR steps, data MSB first
    function automatic digest_t digest_byte(digest_t cur, logic [15:0] poly, logic [7:0] data);
        digest_t d;
        int      b;
        d = cur;
        for (b = 7; b >= 0; b--)
        begin
            if (data[b])
            begin
                d.acc = d.acc ^ d.key;
            end
            if (d.key[0])
            begin
                d.key = (d.key >> 1) ^ poly;
            end
            else
            begin
                d.key = d.key >> 1;
            end
        end
        return d;
    endfunction

endpackage

FILE: design/sfe_front.sv
// Front end: takes a reading, converts temperature and humidity to BCD, runs the digest.
module sfe_front (
    input  logic                clk,
    input  logic                rst_n,
    input  sfe_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         sensor_id,
    input  logic [2:0]          channel,
    input  logic signed [10:0]  temp_tenths,
    input  logic [7:0]          humidity,
    input  logic                batt_good,
    input  logic                startup,
    input  logic                q_full,
    output logic                q_push,
    output sfe_pkg::frame_t     q_data
);
    import sfe_pkg::*;

    logic                busy_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [31:0]         id_reg;
    logic [2:0]          chan_reg;
    logic                start_reg;
    logic                batt_reg;
    logic                neg_reg;
    logic [9:0]          t_reg;
    logic [6:0]          hum_reg;
    logic [3:0]          hund_reg;
    logic [6:0]          rem_reg;
    logic [3:0]          t_tens_reg;
    logic [3:0]          t_units_reg;
    logic [3:0]          h_tens_reg;
    logic [3:0]          h_units_reg;
    logic [7:0]          sum_reg;
    digest_t             dig_reg;

    logic                accept;
    logic signed [11:0]  t_wide;
    logic [9:0]          t_clamp;
    logic [6:0]          hum_sat;
    logic [15:0]         hund_prod;
    logic [9:0]          rem_full;
    logic [14:0]         t_tens_prod;
    logic [14:0]         h_tens_prod;
    logic [6:0]          t_units_full;
    logic [6:0]          h_units_full;
    logic [7:0]          cur_byte;
    logic [7:0]          type_chan;
    logic [7:0]          temp_hi;
    logic [7:0]          temp_lo;
    logic [7:0]          hum_bcd;
    logic [7:0]          sum_next;
    digest_t             dig_next;
    logic                done;

    assign in_stall = busy_reg;
    assign accept   = in_valid && !busy_reg;
    assign done     = busy_reg && (step_reg == LAST_STEP);
    assign q_push   = done && !q_full;

    // negative: 1000 - magnitude, then clamp to 0..999
    always_comb
    begin
        t_wide = temp_tenths[10] ? (12'sd1000 + 12'(temp_tenths)) : 12'(temp_tenths);
        priority if (t_wide < 12'sd0)
        begin
            t_clamp = 10'd0;
        end
        else if (t_wide > 12'sd999)
        begin
            t_clamp = 10'd999;
        end
        else
        begin
            t_clamp = t_wide[9:0];
        end
        hum_sat = (humidity > 8'd99) ? 7'd99 : humidity[6:0];
    end

    // reciprocal multiplies, exact over 0..999 and 0..99
    assign hund_prod    = 16'(t_reg) * 16'd41;
    assign rem_full     = t_reg - 10'(hund_reg) * 10'd100;
    assign t_tens_prod  = 15'(rem_reg) * 15'd205;
    assign h_tens_prod  = 15'(hum_reg) * 15'd205;
    assign t_units_full = rem_reg - 7'(t_tens_reg) * 7'd10;
    assign h_units_full = hum_reg - 7'(h_tens_reg) * 7'd10;

    assign type_chan = {cfg.sensor_type, !start_reg, chan_reg};
    assign temp_hi   = {hund_reg, t_tens_reg};
    assign temp_lo   = {t_units_reg, neg_reg, 1'b0, batt_reg, 1'b0};
    assign hum_bcd   = {h_tens_reg, h_units_reg};

    // frame byte 2 + step
    always_comb
    begin
        unique case (step_reg)
            4'd0:    cur_byte = id_reg[31:24];
            4'd1:    cur_byte = id_reg[23:16];
            4'd2:    cur_byte = id_reg[15:8];
            4'd3:    cur_byte = id_reg[7:0];
            4'd4:    cur_byte = type_chan;
            4'd10:   cur_byte = temp_hi;
            4'd11:   cur_byte = temp_lo;
            4'd12:   cur_byte = hum_bcd;
            4'd13:   cur_byte = UV_HIGH;
            4'd14:   cur_byte = UV_LOW;
            default: cur_byte = 8'h00;
        endcase
    end

    assign dig_next = digest_byte(dig_reg, cfg.generator, cur_byte);
    assign sum_next = sum_reg + cur_byte;

    always_comb
    begin
        q_data.digest    = dig_next.acc;
        q_data.sensor_id = id_reg;
        q_data.type_chan = type_chan;
        q_data.temp_hi   = temp_hi;
        q_data.temp_lo   = temp_lo;
        q_data.hum_bcd   = hum_bcd;
        q_data.checksum  = ~sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (q_push)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg && !done)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg      <= sensor_id;
            chan_reg    <= channel;
            start_reg   <= startup;
            batt_reg    <= batt_good;
            neg_reg     <= temp_tenths[10];
            t_reg       <= t_clamp;
            hum_reg     <= hum_sat;
            sum_reg     <= 8'h00;
            dig_reg.acc <= 16'h0000;
            dig_reg.key <= cfg.key;
        end
        else if (busy_reg && !done)
        begin
            sum_reg <= sum_next;
            dig_reg <= dig_next;
            // digit pipeline rides along the first four steps
            unique case (step_reg)
                4'd0:
                begin
                    hund_reg   <= hund_prod[15:12];
                    h_tens_reg <= h_tens_prod[14:11];
                end
                4'd1:
                begin
                    rem_reg     <= rem_full[6:0];
                    h_units_reg <= h_units_full[3:0];
                end
                4'd2:    t_tens_reg  <= t_tens_prod[14:11];
                4'd3:    t_units_reg <= t_units_full[3:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: design/sfe_queue.sv
// Two-entry queue of classified frames between front and back.
module sfe_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sfe_pkg::frame_t  push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output sfe_pkg::frame_t  head
);
    import sfe_pkg::*;

    frame_t      mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/sfe_back.sv
// Back end: walks the queued frame one byte per beat into the output register.
module sfe_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  sfe_pkg::frame_t              q_head,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sfe_pkg::POS_W-1:0]    byte_index,
    output logic [7:0]                   byte_value,
    output logic                         last_byte
);
    import sfe_pkg::*;

    logic [POS_W-1:0]  pos_reg;
    logic              out_valid_reg;
    logic [POS_W-1:0]  index_reg;
    logic [7:0]        value_reg;
    logic              last_reg;
    logic              load;
    logic [7:0]        sel_byte;

    assign load  = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop = load && (pos_reg == LAST_POS);

    always_comb
    begin
        unique case (pos_reg)
            5'd0:    sel_byte = q_head.digest[15:8];
            5'd1:    sel_byte = q_head.digest[7:0];
            5'd2:    sel_byte = q_head.sensor_id[31:24];
            5'd3:    sel_byte = q_head.sensor_id[23:16];
            5'd4:    sel_byte = q_head.sensor_id[15:8];
            5'd5:    sel_byte = q_head.sensor_id[7:0];
            5'd6:    sel_byte = q_head.type_chan;
            5'd12:   sel_byte = q_head.temp_hi;
            5'd13:   sel_byte = q_head.temp_lo;
            5'd14:   sel_byte = q_head.hum_bcd;
            5'd15:   sel_byte = UV_HIGH;
            5'd16:   sel_byte = UV_LOW;
            5'd17:   sel_byte = q_head.checksum;
            default: sel_byte = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || !out_stall)
            begin
                out_valid_reg <= q_valid;
            end
            if (load)
            begin
                pos_reg <= (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg <= pos_reg;
            value_reg <= sel_byte;
            last_reg  <= (pos_reg == LAST_POS);
        end
    end

    assign out_valid  = out_valid_reg;
    assign byte_index = index_reg;
    assign byte_value = value_reg;
    assign last_byte  = last_reg;

endmodule

FILE: design/sensor_frame_encoder.sv
// Top level of the sensor frame encoder: config registers, front, queue and back.
//
// Each accepted reading comes out as an 18-byte radio frame, one byte per output
// beat, bytes 0 to 17 in order with last_byte set on byte 17. Throughput is set by
// the one-byte-wide output port; the front digests one frame byte per cycle through
// the LFSR, so it runs ahead and refills the queue while the back end is still
// streaming the previous frame. A frame's first byte reaches the output register
// after the front's digest steps and the queue, once queue and output are free.
// in_stall is high while the front is busy on a reading or waiting for room in the
// two-entry queue. Registers sit on an APB port at byte addresses 0x0 (digest
// generator), 0x4 (digest key) and 0x8 (sensor type); they reset to 0x8810, 0x5412
// and 2 and should only be written while no frame is in flight.
module sensor_frame_encoder (
    input  logic                       clk,
    input  logic                       rst_n,
    // APB config port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // reading input
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [31:0]                sensor_id,
    input  logic [2:0]                 channel,
    input  logic signed [10:0]         temp_tenths,
    input  logic [7:0]                 humidity,
    input  logic                       batt_good,
    input  logic                       startup,
    // frame byte output
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [sfe_pkg::POS_W-1:0]  byte_index,
    output logic [7:0]                 byte_value,
    output logic                       last_byte
);
    import sfe_pkg::*;

    cfg_t      cfg_reg;
    reg_idx_t  reg_sel;
    logic      cfg_write;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    frame_t    q_data;
    frame_t    q_head;

    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.generator   <= GEN_RESET;
            cfg_reg.key         <= KEY_RESET;
            cfg_reg.sensor_type <= TYPE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_GENERATOR: cfg_reg.generator   <= pwdata[15:0];
                REG_KEY:       cfg_reg.key         <= pwdata[15:0];
                REG_TYPE:      cfg_reg.sensor_type <= pwdata[3:0];
                default:       ; // unmapped slot, write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_GENERATOR: prdata = {16'h0000, cfg_reg.generator};
            REG_KEY:       prdata = {16'h0000, cfg_reg.key};
            REG_TYPE:      prdata = {28'h0000000, cfg_reg.sensor_type};
            default:       prdata = 32'h00000000;
        endcase
    end

    // front: latch reading, BCD digits and digest over bytes 2..16
    sfe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sensor_id   (sensor_id),
        .channel     (channel),
        .temp_tenths (temp_tenths),
        .humidity    (humidity),
        .batt_good   (batt_good),
        .startup     (startup),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_data)
    );

    // decouples front from a stalled output
    sfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    // back: byte serializer with registered output
    sfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .byte_index (byte_index),
        .byte_value (byte_value),
        .last_byte  (last_byte)
    );

endmodule

FILE: design/sfe_checker.sv
// Port-level checks on the frame byte stream of the sensor frame encoder.
module sfe_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [sfe_pkg::POS_W-1:0]  byte_index,
    input  logic [7:0]                 byte_value,
    input  logic                       last_byte
);
    import sfe_pkg::*;

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(byte_index) && $stable(byte_value)
                                   && $stable(last_byte))
        else $error("stalled output beat changed");

    // last marker only on the final position
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_byte == (byte_index == LAST_POS)))
        else $error("last_byte does not match byte_index");

    // positions advance by one inside a frame
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_byte |=>
            !out_valid || (byte_index == $past(byte_index) + 5'd1))
        else $error("frame byte skipped or repeated");

    // fixed UV filler
    a_uv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_index == 5'd15) |-> (byte_value == UV_HIGH))
        else $error("UV filler byte wrong");

endmodule

bind sensor_frame_encoder sfe_checker u_sfe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .byte_index (byte_index),
    .byte_value (byte_value),
    .last_byte  (last_byte)
);
